// File: sv/esc_pkg.sv
package esc_pkg;

  localparam int CoefW = 48;
  localparam int HumAW = 40;
  localparam int HumBW = 32;
  localparam int RawW = 20;
  localparam int KindW = 2;
  localparam int StatW = 2;
  localparam int HumOutW = 17;
  localparam int IdxW = 3;
  localparam int DatW = 64;

  localparam logic [KindW-1:0] KIND_TEMP  = 2'd0;
  localparam logic [KindW-1:0] KIND_PRESS = 2'd1;
  localparam logic [KindW-1:0] KIND_HUMID = 2'd2;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_NO_CAL   = 2'd1;
  localparam logic [StatW-1:0] ST_DIV_ZERO = 2'd2;

  localparam logic [IdxW-1:0] REG_TEMP    = 3'd0;
  localparam logic [IdxW-1:0] REG_PRESS_A = 3'd1;
  localparam logic [IdxW-1:0] REG_PRESS_B = 3'd2;
  localparam logic [IdxW-1:0] REG_PRESS_C = 3'd3;
  localparam logic [IdxW-1:0] REG_HUMID_A = 3'd4;
  localparam logic [IdxW-1:0] REG_HUMID_B = 3'd5;
  localparam logic [IdxW-1:0] REG_VALID   = 3'd6;

  localparam logic signed [DatW-1:0] C_T_OFS    = 64'sd128000;
  localparam logic signed [DatW-1:0] C_P_BASE   = 64'sd1048576;
  localparam logic signed [DatW-1:0] C_P_SCALE  = 64'sd3125;
  localparam logic signed [DatW-1:0] C_H_OFS    = 64'sd76800;
  localparam logic signed [DatW-1:0] C_H_MAX    = 64'sd419430400;
  localparam logic signed [DatW-1:0] C_H_RND    = 64'sd16384;
  localparam logic signed [DatW-1:0] C_H_BIAS   = 64'sd2097152;
  localparam logic signed [DatW-1:0] C_H_HALF   = 64'sd32768;
  localparam logic signed [DatW-1:0] C_H_RND2   = 64'sd8192;

  function automatic logic signed [DatW-1:0] sx32(input logic [DatW-1:0] v);
    return signed'({{32{v[31]}}, v[31:0]});
  endfunction

  function automatic logic signed [DatW-1:0] sx16(input logic [15:0] v);
    return signed'({{48{v[15]}}, v});
  endfunction

  function automatic logic signed [DatW-1:0] sx8(input logic [7:0] v);
    return signed'({{56{v[7]}}, v});
  endfunction

  function automatic logic signed [DatW-1:0] zx16(input logic [15:0] v);
    return signed'({48'd0, v});
  endfunction

endpackage

// File: sv/esc_sample_if.sv
interface esc_sample_if;
  import esc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [RawW-1:0]   raw_reading;
  modport source(output valid, kind, raw_reading, input ready);
  modport sink(input valid, kind, raw_reading, output ready);
endinterface

// File: sv/esc_result_if.sv
interface esc_result_if;
  import esc_pkg::*;
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    result_kind;
  logic signed [31:0]  temperature_centi;
  logic [31:0]         pressure_q24_8;
  logic [HumOutW-1:0]  humidity_q22_10;
  logic [StatW-1:0]    status;
  modport source(output valid, result_kind, temperature_centi, pressure_q24_8,
                 humidity_q22_10, status, input ready);
  modport sink(input valid, result_kind, temperature_centi, pressure_q24_8,
               humidity_q22_10, status, output ready);
endinterface

// File: sv/esc_cfg_if.sv
interface esc_cfg_if;
  import esc_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] index;
  logic [CoefW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/esc_mul.sv
module esc_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic signed [esc_pkg::DatW-1:0]  a,
  input  logic signed [esc_pkg::DatW-1:0]  b,
  output logic                             done,
  output logic signed [esc_pkg::DatW-1:0]  y
);
  import esc_pkg::*;

  logic            busy;
  logic [DatW-1:0] mc;
  logic [DatW-1:0] mp;
  logic [DatW-1:0] acc;

  assign y = signed'(acc);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
      acc  <= '0;
      mc   <= a;
      mp   <= b;
    end else if (busy) begin
      if (mp == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        if (mp[0]) acc <= acc + mc;
        mc <= mc << 1;
        mp <= mp >> 1;
      end
    end
  end
endmodule

// File: sv/esc_div.sv
module esc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic signed [esc_pkg::DatW-1:0]  num,
  input  logic signed [esc_pkg::DatW-1:0]  den,
  output logic                             done,
  output logic signed [esc_pkg::DatW-1:0]  quo
);
  import esc_pkg::*;

  localparam int CntW = $clog2(DatW + 1);

  logic            busy;
  logic            neg;
  logic [CntW-1:0] cnt;
  logic [DatW-1:0] q;
  logic [DatW-1:0] dv;
  logic [DatW:0]   rem;
  logic [DatW:0]   sh;
  logic [DatW:0]   diff;

  assign sh   = {rem[DatW-1:0], q[DatW-1]};
  assign diff = sh - {1'b0, dv};
  assign quo  = neg ? -signed'(q) : signed'(q);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
      neg  <= num[DatW-1] ^ den[DatW-1];
      q    <= num[DatW-1] ? -num : num;
      dv   <= den[DatW-1] ? -den : den;
      rem  <= '0;
      cnt  <= CntW'(DatW);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
        if (!diff[DatW]) begin
          rem <= diff;
          q   <= {q[DatW-2:0], 1'b1};
        end else begin
          rem <= sh;
          q   <= {q[DatW-2:0], 1'b0};
        end
      end
    end
  end
endmodule

// File: sv/env_sensor_compensation_unit.sv
// Environmental sensor compensation unit.
// samples: one request per raw reading, tagged temperature, pressure or
//   humidity. ready is high only while no reading is in work.
// cfg: coefficient and calibration-valid writes, always ready; write only
//   while idle.
// results: one request per reading, held in an output register until taken.
// A short microcode sequence drives one shared bit-serial multiplier
//   (one multiplier bit per cycle, stopping once the remaining multiplier
//   bits are all zero) and a bit-serial divider. A pressure reading whose
//   divisor is zero ends before the division with a divide-by-zero status.
//   Readings without valid calibration, or of an unused kind, skip the
//   microcode and go straight to the result stage.
// Throughput: one reading at a time; the next is taken once the previous
//   result is in the output register.
// Stall: while results is stalled a finished result waits, and a new
//   reading may be accepted and computed meanwhile.
// Reset: clears all coefficients, calibration valid and the stored fine
//   temperature, and drops any reading in work.
module env_sensor_compensation_unit (
  input logic         clk,
  input logic         rst,
  esc_sample_if.sink  samples,
  esc_cfg_if.sink     cfg,
  esc_result_if.source results
);
  import esc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE} state_t;

  state_t state;
  logic [4:0] pc;
  logic [KindW-1:0] kind_r;
  logic [RawW-1:0]  raw_r;
  logic [CoefW-1:0] temp_c, pa_c, pb_c, pc_c;
  logic [HumAW-1:0] ha_c;
  logic [HumBW-1:0] hb_c;
  logic             cal_ok;
  logic [31:0]      fine_t;

  logic signed [DatW-1:0] ra, rb, rc, rd, prod;
  logic signed [DatW-1:0] mul_a, mul_b, mul_y, div_n, div_d, div_q;
  logic mul_go, mul_done, div_go, div_done;

  logic signed [31:0]    pend_t;
  logic [31:0]           pend_p;
  logic [HumOutW-1:0]    pend_h;
  logic [StatW-1:0]      pend_st;

  logic signed [DatW-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [DatW-1:0] h1, h2, h3, h4, h5, h6;
  logic signed [DatW-1:0] adc_tp, adc_h;
  logic signed [DatW-1:0] tf, tcent, pv1, pfin, hv, hclamp;

  assign t1 = zx16(temp_c[15:0]);
  assign t2 = sx16(temp_c[31:16]);
  assign t3 = sx16(temp_c[47:32]);
  assign p1 = zx16(pa_c[15:0]);
  assign p2 = sx16(pa_c[31:16]);
  assign p3 = sx16(pa_c[47:32]);
  assign p4 = sx16(pb_c[15:0]);
  assign p5 = sx16(pb_c[31:16]);
  assign p6 = sx16(pb_c[47:32]);
  assign p7 = sx16(pc_c[15:0]);
  assign p8 = sx16(pc_c[31:16]);
  assign p9 = sx16(pc_c[47:32]);
  assign h1 = signed'({56'd0, ha_c[7:0]});
  assign h2 = sx16(ha_c[23:8]);
  assign h3 = signed'({56'd0, ha_c[31:24]});
  assign h6 = sx8(ha_c[39:32]);
  assign h4 = sx16(hb_c[15:0]);
  assign h5 = sx16(hb_c[31:16]);

  assign adc_tp = signed'({44'd0, raw_r});
  assign adc_h  = zx16(raw_r[15:0]);

  always_comb begin
    tf     = ra + (sx32(prod) >>> 14);
    tcent  = sx32((tf <<< 2) + tf + 64'sd128) >>> 8;
    pv1    = prod >>> 33;
    pfin   = ((ra + rc + (prod >>> 19)) >>> 8) + (p7 <<< 4);
    hv     = sx32(ra - (sx32(prod) >>> 4));
    hclamp = hv;
    if (hv[DatW-1]) hclamp = '0;
    else if (hv > C_H_MAX) hclamp = C_H_MAX;
  end

  assign samples.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;

  esc_mul u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .y(mul_y)
  );

  esc_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_n), .den(div_d),
    .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    mul_go <= 1'b0;
    div_go <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      pc      <= '0;
      temp_c  <= '0;
      pa_c    <= '0;
      pb_c    <= '0;
      pc_c    <= '0;
      ha_c    <= '0;
      hb_c    <= '0;
      cal_ok  <= 1'b0;
      fine_t  <= '0;
      results.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_TEMP:    temp_c <= cfg.data;
          REG_PRESS_A: pa_c   <= cfg.data;
          REG_PRESS_B: pb_c   <= cfg.data;
          REG_PRESS_C: pc_c   <= cfg.data;
          REG_HUMID_A: ha_c   <= cfg.data[HumAW-1:0];
          REG_HUMID_B: hb_c   <= cfg.data[HumBW-1:0];
          REG_VALID:   cal_ok <= cfg.data[0];
          default: ;
        endcase
      end

      if (results.valid && results.ready) results.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            kind_r  <= samples.kind;
            raw_r   <= samples.raw_reading;
            pc      <= '0;
            pend_t  <= '0;
            pend_p  <= '0;
            pend_h  <= '0;
            pend_st <= ST_OK;
            if (!cal_ok) begin
              pend_st <= ST_NO_CAL;
              state   <= S_DONE;
            end else if (samples.kind != KIND_TEMP && samples.kind != KIND_PRESS &&
                         samples.kind != KIND_HUMID) begin
              state <= S_DONE;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            prod  <= mul_y;
            state <= S_EXEC;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ra    <= div_q;
            state <= S_EXEC;
          end
        end
        S_DONE: begin
          if (!results.valid || results.ready) begin
            results.valid             <= 1'b1;
            results.result_kind       <= kind_r;
            results.temperature_centi <= pend_t;
            results.pressure_q24_8    <= pend_p;
            results.humidity_q22_10   <= pend_h;
            results.status            <= pend_st;
            state                     <= S_IDLE;
          end
        end
        S_EXEC: begin
          pc <= pc + 1'b1;
          if (kind_r == KIND_TEMP) begin
            case (pc)
              5'd0: ra <= (adc_tp >>> 3) - (t1 <<< 1);
              5'd1: begin mul_a <= ra; mul_b <= t2; mul_go <= 1'b1; state <= S_MUL; end
              5'd2: begin
                ra <= sx32(prod) >>> 11;
                rb <= (adc_tp >>> 4) - t1;
              end
              5'd3: begin mul_a <= rb; mul_b <= rb; mul_go <= 1'b1; state <= S_MUL; end
              5'd4: rb <= sx32(prod) >>> 12;
              5'd5: begin mul_a <= rb; mul_b <= t3; mul_go <= 1'b1; state <= S_MUL; end
              default: begin
                fine_t <= tf[31:0];
                pend_t <= tcent[31:0];
                state  <= S_DONE;
              end
            endcase
          end else if (kind_r == KIND_PRESS) begin
            case (pc)
              5'd0:  ra <= sx32(64'(fine_t)) - C_T_OFS;
              5'd1:  begin mul_a <= ra; mul_b <= ra; mul_go <= 1'b1; state <= S_MUL; end
              5'd2:  rb <= prod;
              5'd3:  begin mul_a <= rb; mul_b <= p6; mul_go <= 1'b1; state <= S_MUL; end
              5'd4:  rc <= prod;
              5'd5:  begin mul_a <= ra; mul_b <= p5; mul_go <= 1'b1; state <= S_MUL; end
              5'd6:  rc <= rc + (prod <<< 17) + (p4 <<< 35);
              5'd7:  begin mul_a <= rb; mul_b <= p3; mul_go <= 1'b1; state <= S_MUL; end
              5'd8:  rd <= prod >>> 8;
              5'd9:  begin mul_a <= ra; mul_b <= p2; mul_go <= 1'b1; state <= S_MUL; end
              5'd10: rd <= (64'sd1 <<< 47) + rd + (prod <<< 12);
              5'd11: begin mul_a <= rd; mul_b <= p1; mul_go <= 1'b1; state <= S_MUL; end
              5'd12: begin
                rd <= pv1;
                if (pv1 == '0) begin
                  pend_st <= ST_DIV_ZERO;
                  state   <= S_DONE;
                end
              end
              5'd13: ra <= C_P_BASE - adc_tp;
              5'd14: begin
                mul_a  <= (ra <<< 31) - rc;
                mul_b  <= C_P_SCALE;
                mul_go <= 1'b1;
                state  <= S_MUL;
              end
              5'd15: begin div_n <= prod; div_d <= rd; div_go <= 1'b1; state <= S_DIV; end
              5'd16: rb <= ra >>> 13;
              5'd17: begin mul_a <= p9; mul_b <= rb; mul_go <= 1'b1; state <= S_MUL; end
              5'd18: begin mul_a <= prod; mul_b <= rb; mul_go <= 1'b1; state <= S_MUL; end
              5'd19: rc <= prod >>> 25;
              5'd20: begin mul_a <= p8; mul_b <= ra; mul_go <= 1'b1; state <= S_MUL; end
              default: begin
                pend_p <= pfin[31:0];
                state  <= S_DONE;
              end
            endcase
          end else begin
            case (pc)
              5'd0:  ra <= sx32(64'(fine_t)) - C_H_OFS;
              5'd1:  begin mul_a <= h5; mul_b <= ra; mul_go <= 1'b1; state <= S_MUL; end
              5'd2:  rb <= sx32((adc_h <<< 14) - (h4 <<< 20) - prod + C_H_RND) >>> 15;
              5'd3:  begin mul_a <= ra; mul_b <= h6; mul_go <= 1'b1; state <= S_MUL; end
              5'd4:  rc <= sx32(prod) >>> 10;
              5'd5:  begin mul_a <= ra; mul_b <= h3; mul_go <= 1'b1; state <= S_MUL; end
              5'd6:  rd <= (sx32(prod) >>> 11) + C_H_HALF;
              5'd7:  begin mul_a <= rc; mul_b <= rd; mul_go <= 1'b1; state <= S_MUL; end
              5'd8:  rc <= (sx32(prod) >>> 10) + C_H_BIAS;
              5'd9:  begin mul_a <= rc; mul_b <= h2; mul_go <= 1'b1; state <= S_MUL; end
              5'd10: rc <= sx32(prod + C_H_RND2) >>> 14;
              5'd11: begin mul_a <= rb; mul_b <= rc; mul_go <= 1'b1; state <= S_MUL; end
              5'd12: begin
                ra <= prod;
                rd <= sx32(prod) >>> 15;
              end
              5'd13: begin mul_a <= rd; mul_b <= rd; mul_go <= 1'b1; state <= S_MUL; end
              5'd14: rd <= sx32(prod) >>> 7;
              5'd15: begin mul_a <= rd; mul_b <= h1; mul_go <= 1'b1; state <= S_MUL; end
              default: begin
                pend_h <= hclamp[HumOutW+11:12];
                state  <= S_DONE;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: test/tb_top.sv
module tb_top;
  import esc_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int LongHold = 600;
  localparam int NumPhases = 7;
  localparam int PhaseItems = 118;

  typedef struct {
    logic [KindW-1:0]   kind;
    logic signed [31:0] temp;
    logic [31:0]        press;
    logic [HumOutW-1:0] humid;
    logic [StatW-1:0]   status;
  } reading_t;

  class comp_board;
    logic [CoefW-1:0] t_reg, pa_reg, pb_reg, pc_reg;
    logic [HumAW-1:0] ha_reg;
    logic [HumBW-1:0] hb_reg;
    bit               cal_ok;
    int               fine_temp;
    reading_t         expected[$];
    int               errors, checked, div_zero, no_cal;

    function new();
      t_reg = '0; pa_reg = '0; pb_reg = '0; pc_reg = '0;
      ha_reg = '0; hb_reg = '0; cal_ok = 0; fine_temp = 0;
      errors = 0; checked = 0; div_zero = 0; no_cal = 0;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [CoefW-1:0] d);
      case (idx)
        REG_TEMP:    t_reg = d;
        REG_PRESS_A: pa_reg = d;
        REG_PRESS_B: pb_reg = d;
        REG_PRESS_C: pc_reg = d;
        REG_HUMID_A: ha_reg = d[HumAW-1:0];
        REG_HUMID_B: hb_reg = d[HumBW-1:0];
        REG_VALID:   cal_ok = d[0];
        default: ;
      endcase
    endfunction

    function int temp_centi(int adc);
      int t1, t2, t3, a, b, v1, v2;
      t1 = int'(t_reg[15:0]);
      t2 = int'(signed'(t_reg[31:16]));
      t3 = int'(signed'(t_reg[47:32]));
      a = (adc >>> 3) - (t1 <<< 1);
      v1 = (a * t2) >>> 11;
      b = (adc >>> 4) - t1;
      v2 = (((b * b) >>> 12) * t3) >>> 14;
      fine_temp = v1 + v2;
      return (fine_temp * 5 + 128) >>> 8;
    endfunction

    function bit press_q24_8(longint adc, output logic [31:0] res);
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q, n;
      p1 = longint'(pa_reg[15:0]);
      p2 = longint'(signed'(pa_reg[31:16]));
      p3 = longint'(signed'(pa_reg[47:32]));
      p4 = longint'(signed'(pb_reg[15:0]));
      p5 = longint'(signed'(pb_reg[31:16]));
      p6 = longint'(signed'(pb_reg[47:32]));
      p7 = longint'(signed'(pc_reg[15:0]));
      p8 = longint'(signed'(pc_reg[31:16]));
      p9 = longint'(signed'(pc_reg[47:32]));
      res = '0;
      v1 = longint'(fine_temp) - longint'(C_T_OFS);
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) return 0;
      p = longint'(C_P_BASE) - adc;
      n = ((p <<< 31) - v2) * longint'(C_P_SCALE);
      p = (v1 == -1) ? -n : n / v1;
      q = p >>> 13;
      v1 = (p9 * q * q) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      res = p[31:0];
      return 1;
    endfunction

    function logic [HumOutW-1:0] humid_q22_10(int adc);
      int h1, h2, h3, h4, h5, h6, v, x, y, s;
      h1 = int'(ha_reg[7:0]);
      h2 = int'(signed'(ha_reg[23:8]));
      h3 = int'(ha_reg[31:24]);
      h6 = int'(signed'(ha_reg[39:32]));
      h4 = int'(signed'(hb_reg[15:0]));
      h5 = int'(signed'(hb_reg[31:16]));
      v = fine_temp - int'(C_H_OFS);
      x = (((adc <<< 14) - (h4 <<< 20) - (h5 * v)) + int'(C_H_RND)) >>> 15;
      y = ((v * h6) >>> 10) * (((v * h3) >>> 11) + int'(C_H_HALF));
      y = ((y >>> 10) + int'(C_H_BIAS)) * h2 + int'(C_H_RND2);
      y = y >>> 14;
      v = x * y;
      s = v >>> 15;
      v = v - ((((s * s) >>> 7) * h1) >>> 4);
      if (v < 0) v = 0;
      if (v > int'(C_H_MAX)) v = int'(C_H_MAX);
      return HumOutW'(v >>> 12);
    endfunction

    function void note_sample(logic [KindW-1:0] k, logic [RawW-1:0] r);
      reading_t e;
      logic [31:0] p;
      e.kind = k; e.temp = '0; e.press = '0; e.humid = '0; e.status = ST_OK;
      if (!cal_ok) begin
        e.status = ST_NO_CAL;
      end else begin
        case (k)
          KIND_TEMP:  e.temp = temp_centi(int'(r));
          KIND_PRESS: begin
            if (press_q24_8(longint'(r), p)) e.press = p;
            else e.status = ST_DIV_ZERO;
          end
          KIND_HUMID: e.humid = humid_q22_10(int'(r[15:0]));
          default: ;
        endcase
      end
      expected.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    endtask

    task check_result(reading_t g);
      reading_t e;
      if (expected.size() == 0) begin
        report("unexpected request", {62'd0, g.kind}, 64'd0);
        return;
      end
      e = expected.pop_front();
      checked++;
      if (e.status == ST_DIV_ZERO) div_zero++;
      if (e.status == ST_NO_CAL) no_cal++;
      if (g.kind !== e.kind) report("result_kind", 64'(g.kind), 64'(e.kind));
      if (g.temp !== e.temp) report("temperature_centi", 64'(g.temp), 64'(e.temp));
      if (g.press !== e.press) report("pressure_q24_8", 64'(g.press), 64'(e.press));
      if (g.humid !== e.humid) report("humidity_q22_10", 64'(g.humid), 64'(e.humid));
      if (g.status !== e.status) report("status", 64'(g.status), 64'(e.status));
    endtask
  endclass

  logic clk;
  logic rst;
  esc_sample_if samp();
  esc_cfg_if    cfg();
  esc_result_if res();

  env_sensor_compensation_unit u_dut (
    .clk(clk), .rst(rst), .samples(samp), .cfg(cfg), .results(res)
  );

  comp_board board;
  bit quiet;
  int hold_req;
  int stall_left;
  int idle_cycles;
  int cfg_writes;
  reading_t got;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        got.kind = res.result_kind;
        got.temp = res.temperature_centi;
        got.press = res.pressure_q24_8;
        got.humid = res.humidity_q22_10;
        got.status = res.status;
        board.check_result(got);
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((samp.valid && samp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no request moved for %0d cycles", IdleLimit);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CoefW-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    board.set_reg(idx, d);
    cfg_writes++;
  endtask

  task automatic end_writes();
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_reading(logic [KindW-1:0] k, logic [RawW-1:0] r);
    samp.valid <= 1'b1;
    samp.kind <= k;
    samp.raw_reading <= r;
    do @(posedge clk); while (!samp.ready);
    board.note_sample(k, r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      samp.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    samp.valid <= 1'b0;
    @(posedge clk);
    while (board.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_coeffs(logic [CoefW-1:0] t, logic [CoefW-1:0] pa,
                             logic [CoefW-1:0] pb, logic [CoefW-1:0] pc,
                             logic [CoefW-1:0] ha, logic [CoefW-1:0] hb, bit ok);
    write_reg(REG_TEMP, t);
    write_reg(REG_PRESS_A, pa);
    write_reg(REG_PRESS_B, pb);
    write_reg(REG_PRESS_C, pc);
    write_reg(REG_HUMID_A, ha);
    write_reg(REG_HUMID_B, hb);
    write_reg(REG_VALID, {{(CoefW-1){1'b0}}, ok});
    end_writes();
  endtask

  function automatic logic [CoefW-1:0] rand48();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [RawW-1:0] pick_raw(logic [KindW-1:0] k);
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 2) return '0;
    if (sel < 4) return '1;
    if (sel < 8) return RawW'($urandom);
    case (k)
      KIND_TEMP:  return RawW'($urandom_range(480000, 560000));
      KIND_PRESS: return RawW'($urandom_range(330000, 460000));
      default:    return RawW'($urandom_range(15000, 45000));
    endcase
  endfunction

  function automatic logic [KindW-1:0] pick_kind();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) return KIND_TEMP;
    if (sel < 14) return KIND_PRESS;
    if (sel < 19) return KIND_HUMID;
    return '1;
  endfunction

  localparam logic [CoefW-1:0] TypT  = 48'hFC18_6743_6B70;
  localparam logic [CoefW-1:0] TypPA = 48'h0BD0_D643_8E7D;
  localparam logic [CoefW-1:0] TypPB = 48'hFFF9_008C_0B27;
  localparam logic [CoefW-1:0] TypPC = 48'h1770_C6F8_3C8C;
  localparam logic [CoefW-1:0] TypHA = 48'h00_1E_00_016A_4B;
  localparam logic [CoefW-1:0] TypHB = 48'h0000_0032_0139;

  initial begin
    logic [KindW-1:0] k;
    board = new();
    quiet = 0;
    hold_req = 0;
    cfg_writes = 0;
    rst <= 1'b1;
    samp.valid <= 1'b0;
    samp.kind <= KIND_TEMP;
    samp.raw_reading <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_TEMP;
    cfg.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_reading(KIND_TEMP, 20'd519888);
    send_reading(KIND_PRESS, 20'd415148);
    send_reading(KIND_HUMID, 20'd30000);
    send_reading('1, '1);
    wait_drained();

    load_coeffs(TypT, TypPA, TypPB, TypPC, TypHA, TypHB, 1'b1);
    send_reading(KIND_TEMP, 20'd519888);
    send_reading(KIND_PRESS, 20'd415148);
    send_reading(KIND_HUMID, 20'd30000);
    send_reading(KIND_TEMP, '0);
    send_reading(KIND_PRESS, '0);
    send_reading(KIND_HUMID, '0);
    send_reading(KIND_TEMP, '1);
    send_reading(KIND_PRESS, '1);
    send_reading(KIND_HUMID, 20'h0FFFF);
    send_reading(KIND_HUMID, '1);
    send_reading(KIND_HUMID, 20'hF0000);
    send_reading('1, 20'h5A5A5);
    wait_drained();

    load_coeffs(TypT, TypPA & 48'hFFFF_FFFF_0000, TypPB, TypPC, TypHA, TypHB, 1'b1);
    send_reading(KIND_PRESS, 20'd415148);
    send_reading(KIND_TEMP, 20'd519888);
    send_reading(KIND_PRESS, 20'd415148);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: load_coeffs(TypT, TypPA, TypPB, TypPC, TypHA, TypHB, 1'b1);
        1: load_coeffs(TypT ^ 48'($urandom_range(0, 255)), TypPA ^ 48'($urandom_range(0, 255)),
                       TypPB ^ 48'($urandom_range(0, 15)), TypPC ^ 48'($urandom_range(0, 255)),
                       TypHA ^ 48'($urandom_range(0, 63)), TypHB ^ 48'($urandom_range(0, 63)),
                       1'b1);
        2: load_coeffs('1, '1, '1, '1, '1, '1, 1'b1);
        3: load_coeffs('0, '0, '0, '0, '0, '0, 1'b1);
        4: load_coeffs(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 1'b1);
        5: load_coeffs(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 1'b0);
        default: begin
          quiet = 1;
          load_coeffs(TypT, TypPA, TypPB, TypPC, TypHA, TypHB, 1'b1);
        end
      endcase
      if (ph == 0) hold_req = LongHold;
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 1 && i == PhaseItems / 2) wait_drained();
        k = pick_kind();
        send_reading(k, pick_raw(k));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d readings over %0d register writes", board.checked, cfg_writes);
    $display("  %0d without calibration, %0d with a zero pressure divisor",
             board.no_cal, board.div_zero);
    if (board.errors == 0 && board.expected.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/esc_pkg.sv
sv/esc_sample_if.sv
sv/esc_result_if.sv
sv/esc_cfg_if.sv
sv/esc_mul.sv
sv/esc_div.sv
sv/env_sensor_compensation_unit.sv
test/tb_top.sv
